### hdl/bde_pkg.sv
// Shared types and codes for the bounded deque engine.
`timescale 1ns / 1ps
package bde_pkg;

    localparam int VALUE_W = 32;

    // request codes
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_LIST       = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_LIST
    } op_kind_t;

    typedef struct packed {
        op_kind_t                   kind;
        logic                       at_back;
        logic signed [VALUE_W-1:0]  value;
    } cmd_t;

endpackage

### hdl/bde_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/bde_front.sv
// Front end: takes requests and classifies them into deque commands.
`timescale 1ns / 1ps
module bde_front (
    input  logic                               start,
    input  logic                               busy,
    input  logic [2:0]                         req_type,
    input  logic signed [bde_pkg::VALUE_W-1:0] value,
    output logic                               push,
    output bde_pkg::cmd_t                      cmd
);
    import bde_pkg::*;

    logic known;

    always_comb
    begin
        known       = 1'b1;
        cmd.value   = value;
        cmd.kind    = OP_PUSH;
        cmd.at_back = 1'b0;
        unique case (req_type)
            REQ_PUSH_FRONT:
            begin
                cmd.kind = OP_PUSH;
            end
            REQ_PUSH_BACK:
            begin
                cmd.kind    = OP_PUSH;
                cmd.at_back = 1'b1;
            end
            REQ_POP_FRONT:
            begin
                cmd.kind = OP_POP;
            end
            REQ_POP_BACK:
            begin
                cmd.kind    = OP_POP;
                cmd.at_back = 1'b1;
            end
            REQ_LIST:
            begin
                cmd.kind = OP_LIST;
            end
            default:
            begin
                // unused codes are dropped without a result
                known = 1'b0;
            end
        endcase
    end

    assign push = start && !busy && known;

endmodule

### hdl/bde_cmd_fifo.sv
// Two-entry command queue between front end and back end.
`timescale 1ns / 1ps
module bde_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bde_pkg::cmd_t push_cmd,
    input  logic          pop,
    output bde_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);
    import bde_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hdl/bde_back.sv
// Back end: executes deque commands against the circular store.
`timescale 1ns / 1ps
module bde_back #(
    parameter int DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bde_pkg::cmd_t                      cmd,
    input  logic                               cmd_empty,
    output logic                               cmd_pop,
    output logic                               strobe,
    output logic [1:0]                         status,
    output logic signed [bde_pkg::VALUE_W-1:0] value_res,
    output logic                               last
);
    import bde_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IW + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_LIST = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [IW-1:0]       front_reg;
    logic [IW-1:0]       front_next;
    logic [CW-1:0]       occ_reg;
    logic [CW-1:0]       occ_next;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic                strobe_reg;
    logic                strobe_next;
    logic [1:0]          status_reg;
    logic [1:0]          status_next;
    logic [VALUE_W-1:0]  value_reg;
    logic [VALUE_W-1:0]  value_next;
    logic                last_reg;
    logic                last_next;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [IW-1:0]       ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;
    logic                q_full;
    logic                q_empty;
    logic [IW-1:0]       front_dec;
    logic                list_done;

    function automatic logic [IW-1:0] slot_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] s;
        begin
            s = SW'(base) + SW'(off);
            if (s >= SW'(DEPTH))
            begin
                s = s - SW'(DEPTH);
            end
            return s[IW-1:0];
        end
    endfunction

    assign q_full    = (occ_reg == CW'(DEPTH));
    assign q_empty   = (occ_reg == '0);
    assign front_dec = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - 1'b1;
    assign list_done = (cnt_reg == occ_reg);

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        occ_next    = occ_reg;
        cnt_next    = cnt_reg;
        strobe_next = 1'b0;
        status_next = STAT_OK;
        value_next  = '0;
        last_next   = 1'b1;
        cmd_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = front_reg;
        ram_raddr   = front_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        OP_PUSH:
                        begin
                            strobe_next = 1'b1;
                            if (q_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                value_next = cmd.value;
                                occ_next   = occ_reg + 1'b1;
                                if (cmd.at_back)
                                begin
                                    ram_waddr = slot_add(front_reg, occ_reg);
                                end
                                else
                                begin
                                    ram_waddr  = front_dec;
                                    front_next = front_dec;
                                end
                            end
                        end
                        OP_POP:
                        begin
                            if (q_empty)
                            begin
                                strobe_next = 1'b1;
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                occ_next   = occ_reg - 1'b1;
                                state_next = ST_POP;
                                if (cmd.at_back)
                                begin
                                    ram_raddr = slot_add(front_reg, occ_reg - 1'b1);
                                end
                                else
                                begin
                                    front_next = slot_add(front_reg, CW'(1));
                                end
                            end
                        end
                        OP_LIST:
                        begin
                            if (q_empty)
                            begin
                                strobe_next = 1'b1;
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                cnt_next   = CW'(1);
                                state_next = ST_LIST;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                strobe_next = 1'b1;
                value_next  = ram_rdata;
                state_next  = ST_IDLE;
            end
            ST_LIST:
            begin
                // emit the entry read last cycle, fetch the next one
                strobe_next = 1'b1;
                value_next  = ram_rdata;
                last_next   = list_done;
                if (list_done)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_raddr = slot_add(front_reg, cnt_reg);
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            front_reg  <= '0;
            occ_reg    <= '0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            occ_reg    <= occ_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
    end

    bde_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign strobe    = strobe_reg;
    assign status    = status_reg;
    assign value_res = value_reg;
    assign last      = last_reg;

endmodule

### hdl/bounded_deque_engine_core.sv
// Top level of the bounded deque engine.
//
// Requests enter on start/req_type/value and are taken at a rising edge
// where start is high and busy is low. busy rises only while the
// two-entry command queue is full. Unused request codes are dropped.
// Results leave on status/value_res/last, each valid for the one cycle
// that strobe is high; last marks the final result of a request. The
// receiver cannot stall, so results are never held back.
// Push and refused or empty requests pass from the command queue to the
// result registers when the back end is idle; a pop also passes the
// store's registered read in ST_POP. A list streams one stored entry per
// cycle from ST_LIST and holds the back end until its last entry is out.
// Pushes sustain one request per cycle while no pop or list holds the back
// end; a pop holds it while the store's registered read port returns its
// entry. Requests taken during a list wait in the queue.
// Reset empties the deque and the queue; the store is not cleared, as
// only slots written by a push are ever read.
`timescale 1ns / 1ps
module bounded_deque_engine_core #(
    parameter int DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         req_type,
    input  logic signed [bde_pkg::VALUE_W-1:0] value,
    output logic                               strobe,
    output logic [1:0]                         status,
    output logic signed [bde_pkg::VALUE_W-1:0] value_res,
    output logic                               last
);
    import bde_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic front_push;
    logic q_pop;
    logic q_empty;
    logic q_full;

    assign busy = q_full;

    bde_front u_front (
        .start    (start),
        .busy     (q_full),
        .req_type (req_type),
        .value    (value),
        .push     (front_push),
        .cmd      (front_cmd)
    );

    bde_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head     (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    bde_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .strobe    (strobe),
        .status    (status),
        .value_res (value_res),
        .last      (last)
    );

endmodule

### test/testbench.sv
// Self-checking testbench for the bounded deque engine core.
`timescale 1ns / 1ps
module testbench;
    import bde_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_REQS  = 400;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int TAIL_CYCLES  = 2 * DEPTH + 8;
    localparam int MAX_REPORTS  = 10;

    localparam logic [2:0] REQ_UNUSED_MIN = 3'd5;
    localparam logic [2:0] REQ_UNUSED_MAX = 3'd7;

    localparam logic signed [VALUE_W-1:0] ZERO_VALUE = '0;
    localparam logic signed [VALUE_W-1:0] MAX_VALUE  = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] MIN_VALUE  = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] ALL_ONES   = 32'shffff_ffff;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] value_res;
        logic                      last;
    } deque_result_t;

    typedef struct packed {
        logic [2:0]                req;
        logic signed [VALUE_W-1:0] value;
        logic                      typed;
        logic [1:0]                exp_status;
        logic signed [VALUE_W-1:0] exp_value;
    } stim_row_t;

    typedef enum int {
        FILL_BIAS,
        DRAIN_BIAS,
        MIXED
    } traffic_mode_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic [2:0]                req_type = REQ_PUSH_FRONT;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      busy;
    logic                      strobe;
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] value_res;
    logic                      last;

    // mirror of the deque contents
    logic signed [VALUE_W-1:0] mirror_slots [DEPTH];
    int unsigned               mirror_front = 0;
    int unsigned               mirror_count = 0;

    deque_result_t owed_results[$];
    stim_row_t     directed_rows[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;

    bounded_deque_engine_core #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .value     (value),
        .strobe    (strobe),
        .status    (status),
        .value_res (value_res),
        .last      (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Apply one accepted request to the mirror; queue its results when record is set.
    task automatic track_request(input logic [2:0] req, input logic signed [VALUE_W-1:0] v,
                                 input bit record);
        int unsigned   slot;
        int unsigned   k;
        deque_result_t r;
        case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                if (mirror_count == DEPTH)
                    r = {STAT_FULL, ZERO_VALUE, 1'b1};
                else
                begin
                    if (req == REQ_PUSH_FRONT)
                    begin
                        mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
                        mirror_slots[mirror_front] = v;
                    end
                    else
                        mirror_slots[(mirror_front + mirror_count) % DEPTH] = v;
                    mirror_count++;
                    r = {STAT_OK, v, 1'b1};
                end
                if (record)
                    owed_results.push_back(r);
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                if (mirror_count == 0)
                    r = {STAT_EMPTY, ZERO_VALUE, 1'b1};
                else
                begin
                    if (req == REQ_POP_FRONT)
                    begin
                        slot = mirror_front;
                        mirror_front = (mirror_front + 1) % DEPTH;
                    end
                    else
                        slot = (mirror_front + mirror_count - 1) % DEPTH;
                    mirror_count--;
                    r = {STAT_OK, mirror_slots[slot], 1'b1};
                end
                if (record)
                    owed_results.push_back(r);
            end
            REQ_LIST:
            begin
                if (mirror_count == 0)
                begin
                    if (record)
                        owed_results.push_back({STAT_EMPTY, ZERO_VALUE, 1'b1});
                end
                else
                begin
                    for (k = 0; k < mirror_count; k++)
                    begin
                        r = {STAT_OK, mirror_slots[(mirror_front + k) % DEPTH],
                             (k + 1 == mirror_count) ? 1'b1 : 1'b0};
                        if (record)
                            owed_results.push_back(r);
                    end
                end
            end
            default:
            begin
                // unused codes are dropped by the block
            end
        endcase
    endtask

    // Present a request and hold it until the block takes it.
    task automatic issue(input logic [2:0] req, input logic signed [VALUE_W-1:0] v,
                         input bit record);
        start    <= 1'b1;
        req_type <= req;
        value    <= v;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        track_request(req, v, record);
    endtask

    task automatic idle(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic flag_mismatch(input string what, input deque_result_t want,
                                 input deque_result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("ERROR %s at cycle %0d: expected status=%0d value=%h last=%0b",
                     what, cycle_count, want.status, want.value_res, want.last);
            $display("      got status=%0d value=%h last=%0b",
                     got.status, got.value_res, got.last);
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return MAX_VALUE;
            1: return MIN_VALUE;
            2: return ZERO_VALUE;
            3: return ALL_ONES;
            4: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_request(input traffic_mode_t mode);
        int roll;
        int push_lim;
        int pop_lim;
        int list_lim;
        roll = $urandom_range(0, 99);
        case (mode)
            FILL_BIAS:
            begin
                push_lim = 70;
                pop_lim  = 88;
                list_lim = 96;
            end
            DRAIN_BIAS:
            begin
                push_lim = 20;
                pop_lim  = 85;
                list_lim = 95;
            end
            default:
            begin
                push_lim = 45;
                pop_lim  = 85;
                list_lim = 96;
            end
        endcase
        if (roll < push_lim)
            return $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        else if (roll < pop_lim)
            return $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
        else if (roll < list_lim)
            return REQ_LIST;
        else
            return 3'($urandom_range(REQ_UNUSED_MIN, REQ_UNUSED_MAX));
    endfunction

    always @(posedge clk)
    begin : result_check
        deque_result_t got;
        deque_result_t want;
        if (rst_n && strobe !== 1'b0)
        begin
            got = {status, value_res, last};
            if (owed_results.size() == 0)
                flag_mismatch("unexpected result", '0, got);
            else
            begin
                want = owed_results.pop_front();
                if (got !== want)
                    flag_mismatch("result mismatch", want, got);
            end
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t                 row;
        traffic_mode_t             mode;
        logic [2:0]                req;
        logic signed [VALUE_W-1:0] v;
        int                        served;
        int                        burst_len;
        int                        i;

        // empty deque, extremes at both ends, then fill past full with wrap, list the full deque, send an unused code
        directed_rows.push_back({REQ_POP_FRONT, ZERO_VALUE, 1'b1, STAT_EMPTY, ZERO_VALUE});
        directed_rows.push_back({REQ_POP_BACK, ALL_ONES, 1'b1, STAT_EMPTY, ZERO_VALUE});
        directed_rows.push_back({REQ_LIST, ZERO_VALUE, 1'b1, STAT_EMPTY, ZERO_VALUE});
        directed_rows.push_back({REQ_PUSH_FRONT, MAX_VALUE, 1'b1, STAT_OK, MAX_VALUE});
        directed_rows.push_back({REQ_PUSH_BACK, MIN_VALUE, 1'b1, STAT_OK, MIN_VALUE});
        directed_rows.push_back({REQ_LIST, ZERO_VALUE, 1'b0, STAT_OK, ZERO_VALUE});
        directed_rows.push_back({REQ_POP_BACK, ZERO_VALUE, 1'b1, STAT_OK, MIN_VALUE});
        directed_rows.push_back({REQ_POP_FRONT, ZERO_VALUE, 1'b1, STAT_OK, MAX_VALUE});
        for (i = 0; i < DEPTH; i++)
        begin
            v = (32'sh1 << (2 * i)) ^ (i[0] ? ALL_ONES : ZERO_VALUE);
            directed_rows.push_back({i[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK, v,
                                     1'b1, STAT_OK, v});
        end
        directed_rows.push_back({REQ_PUSH_BACK, MAX_VALUE, 1'b1, STAT_FULL, ZERO_VALUE});
        directed_rows.push_back({REQ_PUSH_FRONT, MIN_VALUE, 1'b1, STAT_FULL, ZERO_VALUE});
        directed_rows.push_back({REQ_LIST, ZERO_VALUE, 1'b0, STAT_OK, ZERO_VALUE});
        directed_rows.push_back({REQ_UNUSED_MAX, ALL_ONES, 1'b0, STAT_OK, ZERO_VALUE});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[n])
        begin
            row = directed_rows[n];
            issue(row.req, row.value, !row.typed);
            if (row.typed)
                owed_results.push_back({row.exp_status, row.exp_value, 1'b1});
            idle($urandom_range(0, 2));
        end

        served = 0;
        mode = MIXED;
        while (served < RANDOM_REQS)
        begin
            if ($urandom_range(0, 3) == 0)
                mode = traffic_mode_t'($urandom_range(0, 2));
            burst_len = $urandom_range(1, 12);
            repeat (burst_len)
            begin
                req = pick_request(mode);
                issue(req, pick_value(), 1'b1);
                served++;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: idle(0);
                3:       idle($urandom_range(20, 40));
                default: idle($urandom_range(1, 8));
            endcase
        end
        start <= 1'b0;

        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
hdl/bde_pkg.sv
hdl/bde_ram.sv
hdl/bde_front.sv
hdl/bde_cmd_fifo.sv
hdl/bde_back.sv
hdl/bounded_deque_engine_core.sv
test/testbench.sv
